// ===== rtl/chht_pkg.sv =====
// chht_pkg: shared types and status codes for the chained hash table
// no dependencies
`timescale 1ns / 1ps
package chht_pkg;

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;

  localparam logic [2:0] ST_INSERTED    = 3'd0;
  localparam logic [2:0] ST_PRESENT     = 3'd1;
  localparam logic [2:0] ST_REMOVED     = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND   = 3'd3;
  localparam logic [2:0] ST_FOUND       = 3'd4;
  localparam logic [2:0] ST_FULL        = 3'd5;
  localparam logic [2:0] ST_REACTIVATED = 3'd6;

  // controller to datapath
  typedef struct packed {
    logic clr;        // clear one bucket head after reset
    logic load;       // capture request, restart hash
    logic hash_step;  // fold one bucket byte into the hash
    logic head_ld;    // take the bucket head as the current link
    logic hit_ld;     // record the matching entry
    logic step;       // record visited entry, follow its link
    logic upd;        // apply the operation to the table
    logic lnk_wr;     // point the old chain tail at the new entry
  } chht_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;   // last bucket head being cleared
    logic hash_done;  // all bucket bytes folded
    logic link_ok;    // current link points at an entry
    logic hit;        // key of the entry just read matches
    logic walk_max;   // step bound reached
    logic lnk_need;   // append must also update the chain tail
  } chht_sts_t;

endpackage

// ===== rtl/chht_ram.sv =====
// chht_ram: generic single-port ram, registered read
// no dependencies
`timescale 1ns / 1ps
module chht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ===== rtl/chht_ctrl.sv =====
// chht_ctrl: operation sequencer for the chained hash table
// depends on chht_pkg
`timescale 1ns / 1ps
module chht_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic                out_free,
  input  chht_pkg::chht_sts_t sts,
  output chht_pkg::chht_cmd_t cmd,
  output logic                busy,
  output logic                done
);
  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_HEAD, S_LINK, S_ENT, S_DONE, S_UPD, S_LNKW
  } state_t;
  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    done = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: if (in_fire) begin cmd.load = 1'b1; state_nxt = S_HASH; end
      S_HASH: begin
        if (sts.hash_done) state_nxt = S_HEAD;
        else cmd.hash_step = 1'b1;
      end
      S_HEAD: begin cmd.head_ld = 1'b1; state_nxt = S_LINK; end
      S_LINK: begin
        if (sts.link_ok && !sts.walk_max) state_nxt = S_ENT;
        else state_nxt = S_DONE;
      end
      S_ENT: begin
        if (sts.hit) begin cmd.hit_ld = 1'b1; state_nxt = S_DONE; end
        else begin cmd.step = 1'b1; state_nxt = S_LINK; end
      end
      S_DONE: if (out_free) begin done = 1'b1; state_nxt = S_UPD; end
      S_UPD: begin
        cmd.upd = 1'b1;
        state_nxt = sts.lnk_need ? S_LNKW : S_IDLE;
      end
      S_LNKW: begin cmd.lnk_wr = 1'b1; state_nxt = S_IDLE; end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else state_r <= state_nxt;
  end

  assign busy = (state_r != S_IDLE);
endmodule

// ===== rtl/chht_dp.sv =====
// chht_dp: hash, chain walk registers, memories and result logic
// depends on chht_pkg and chht_ram
`timescale 1ns / 1ps
module chht_dp #(
  parameter int NUM_BUCKETS  = 64,
  parameter int POOL_ENTRIES = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [1:0]          in_func,
  input  logic [63:0]         in_key,
  input  chht_pkg::chht_cmd_t cmd,
  output chht_pkg::chht_sts_t sts,
  output logic [2:0]          res_status,
  output logic                res_present
);
  localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int PW = $clog2(POOL_ENTRIES);
  localparam int CW = $clog2(POOL_ENTRIES + 1);
  localparam int LW = PW + 1;  // link valid, link index
  // hash fold reduced by reciprocal multiplication; 31*h + c stays below 2^TW
  localparam int TW = 15;
  localparam int RS = TW + BW;
  localparam int PRW = 2 * TW + 2;
  localparam int RECIP = (2**RS + NUM_BUCKETS - 1) / NUM_BUCKETS;

  logic [1:0]    func_r;
  logic [63:0]   key_r;
  logic [BW-1:0] hash_r, clr_r;
  logic [1:0]    hcnt_r;
  logic          hstop_r;
  logic          lvalid_r;
  logic [PW-1:0] lidx_r;
  logic          tomb_v_r, tail_v_r;
  logic [PW-1:0] tomb_r, tail_r;
  logic          hit_r, hit_act_r;
  logic [CW-1:0] steps_r, used_r;

  // hash step: h = (h*31 + c) mod NUM_BUCKETS
  logic [7:0]     hbyte;
  logic [TW-1:0]  t, q, qn;
  logic [PRW-1:0] prod;
  logic [BW-1:0]  hred;
  always_comb begin
    unique case (hcnt_r)
      2'd0:    hbyte = key_r[23:16];
      2'd1:    hbyte = key_r[15:8];
      default: hbyte = key_r[7:0];
    endcase
    t = (TW'(hash_r) << 5) - TW'(hash_r) + TW'(hbyte);
    prod = PRW'(t) * PRW'(RECIP);
    q = TW'(prod >> RS);
    qn = q * TW'(NUM_BUCKETS);
    hred = BW'(t - qn);
  end

  // memories
  logic          h_we, k_we, a_we, l_we;
  logic [BW-1:0] h_addr;
  logic [PW-1:0] k_addr, a_addr, l_addr;
  logic [LW-1:0] h_wd, h_rd, l_wd, l_rd;
  logic [63:0]   k_rd;
  logic          a_wd, a_rd;

  chht_ram #(.WIDTH(LW), .DEPTH(NUM_BUCKETS)) u_head (
    .clk(clk), .we(h_we), .addr(h_addr), .wdata(h_wd), .rdata(h_rd)
  );
  chht_ram #(.WIDTH(64), .DEPTH(POOL_ENTRIES)) u_key (
    .clk(clk), .we(k_we), .addr(k_addr), .wdata(key_r), .rdata(k_rd)
  );
  chht_ram #(.WIDTH(1), .DEPTH(POOL_ENTRIES)) u_act (
    .clk(clk), .we(a_we), .addr(a_addr), .wdata(a_wd), .rdata(a_rd)
  );
  chht_ram #(.WIDTH(LW), .DEPTH(POOL_ENTRIES)) u_lnk (
    .clk(clk), .we(l_we), .addr(l_addr), .wdata(l_wd), .rdata(l_rd)
  );

  logic is_ins, room, ins_new;
  assign is_ins  = (func_r == chht_pkg::FUNC_INSERT);
  assign room    = (used_r < CW'(POOL_ENTRIES));
  assign ins_new = is_ins && !hit_r && !tomb_v_r && room;

  assign sts.clr_last  = (clr_r == BW'(NUM_BUCKETS - 1));
  assign sts.hash_done = (hcnt_r == 2'd3);
  assign sts.link_ok   = lvalid_r;
  assign sts.hit       = (k_rd == key_r);
  assign sts.walk_max  = (steps_r == CW'(POOL_ENTRIES));
  assign sts.lnk_need  = ins_new && tail_v_r;

  // result of the operation, from the walk before any update
  always_comb begin
    res_status = chht_pkg::ST_NOT_FOUND;
    res_present = 1'b0;
    if (is_ins) begin
      if (hit_r) begin
        res_status = hit_act_r ? chht_pkg::ST_PRESENT : chht_pkg::ST_REACTIVATED;
        res_present = 1'b1;
      end else if (tomb_v_r || room) begin
        res_status = chht_pkg::ST_INSERTED;
        res_present = 1'b1;
      end else begin
        res_status = chht_pkg::ST_FULL;
      end
    end else if (func_r == chht_pkg::FUNC_REMOVE) begin
      if (hit_r && hit_act_r) res_status = chht_pkg::ST_REMOVED;
    end else if (hit_r && hit_act_r) begin
      // lookup, spare code included
      res_status = chht_pkg::ST_FOUND;
      res_present = 1'b1;
    end
  end

  // memory writes
  always_comb begin
    h_we = 1'b0; h_addr = hash_r; h_wd = '0;
    k_we = 1'b0; k_addr = lidx_r;
    a_we = 1'b0; a_addr = lidx_r; a_wd = 1'b1;
    l_we = 1'b0; l_addr = lidx_r; l_wd = '0;
    if (cmd.clr) begin
      h_we = 1'b1;
      h_addr = clr_r;
    end
    if (cmd.upd) begin
      if (hit_r) begin
        if (is_ins && !hit_act_r) begin
          a_we = 1'b1;
        end else if (func_r == chht_pkg::FUNC_REMOVE && hit_act_r) begin
          a_we = 1'b1;
          a_wd = 1'b0;
        end
      end else if (is_ins && tomb_v_r) begin
        // tombstone reused in place, its link kept
        k_we = 1'b1; k_addr = tomb_r;
        a_we = 1'b1; a_addr = tomb_r;
      end else if (ins_new) begin
        k_we = 1'b1; k_addr = PW'(used_r);
        a_we = 1'b1; a_addr = PW'(used_r);
        l_we = 1'b1; l_addr = PW'(used_r);
        if (!tail_v_r) begin
          h_we = 1'b1;
          h_wd = {1'b1, PW'(used_r)};
        end
      end
    end
    if (cmd.lnk_wr) begin
      l_we = 1'b1;
      l_addr = tail_r;
      l_wd = {1'b1, PW'(used_r - CW'(1))};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      clr_r <= '0;
    end else begin
      if (cmd.clr) clr_r <= clr_r + BW'(1);
      if (cmd.upd && ins_new) used_r <= used_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      key_r <= in_key;
      hash_r <= '0;
      hcnt_r <= '0;
      hstop_r <= 1'b0;
      tomb_v_r <= 1'b0;
      tail_v_r <= 1'b0;
      hit_r <= 1'b0;
      hit_act_r <= 1'b0;
      steps_r <= '0;
    end
    if (cmd.hash_step) begin
      hcnt_r <= hcnt_r + 2'd1;
      // hashing stops at the first zero byte
      if (hbyte == 8'd0) hstop_r <= 1'b1;
      else if (!hstop_r) hash_r <= hred;
    end
    if (cmd.head_ld) begin
      lvalid_r <= h_rd[PW];
      lidx_r <= h_rd[PW-1:0];
    end
    if (cmd.hit_ld) begin
      hit_r <= 1'b1;
      hit_act_r <= a_rd;
    end
    if (cmd.step) begin
      if (!a_rd && !tomb_v_r) begin tomb_v_r <= 1'b1; tomb_r <= lidx_r; end
      tail_v_r <= 1'b1;
      tail_r <= lidx_r;
      lvalid_r <= l_rd[PW];
      lidx_r <= l_rd[PW-1:0];
      steps_r <= steps_r + CW'(1);
    end
  end
endmodule

// ===== rtl/chained_hash_table_with_tombstones_core.sv =====
// chained_hash_table_with_tombstones_core: top level of the chained hash table
// depends on chht_pkg, chht_ctrl, chht_dp, chht_ram
`timescale 1ns / 1ps
// usage
// - input stream: in_tdata = {key, func}, one request per operation
// - output stream: out_tdata = {present, status}, one result per request
// - hashing folds the bucket bytes, then the bucket head is read, then the chain walk
//   reads, compares and steps once per visited entry
// - after the result is registered the table is updated, and an append also links
//   the old chain tail
// - one request at a time; in_tready is low while a request is in flight
// - after reset a clearing pass empties the bucket heads with in_tready low
// - a stalled receiver holds the result in the output register; the walk waits
//   with its result until that register is free
module chained_hash_table_with_tombstones_core #(
  parameter int NUM_BUCKETS  = 64,
  parameter int POOL_ENTRIES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // func[1:0], key[65:2], zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // status[2:0], present[3], zero fill
);
  chht_pkg::chht_cmd_t cmd;
  chht_pkg::chht_sts_t sts;
  logic busy, done, in_fire, out_free;
  logic [2:0] st;
  logic pr;
  logic out_v_r;
  logic [3:0] out_d_r;

  assign out_free  = !out_v_r || out_tready;
  assign in_tready = !busy;
  assign in_fire   = in_tvalid && in_tready;

  chht_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_free(out_free),
    .sts(sts), .cmd(cmd), .busy(busy), .done(done)
  );

  chht_dp #(.NUM_BUCKETS(NUM_BUCKETS), .POOL_ENTRIES(POOL_ENTRIES)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_func(in_tdata[1:0]), .in_key(in_tdata[65:2]),
    .cmd(cmd), .sts(sts), .res_status(st), .res_present(pr)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (done) out_v_r <= 1'b1;
    else if (out_tready) out_v_r <= 1'b0;
    if (done) out_d_r <= {pr, st};
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {4'd0, out_d_r};

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_tready) else $error("request taken while busy");
  a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !done) else $error("double result");
  a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> out_free) else $error("result overwritten");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped while stalled");
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] != 3'd7) else $error("bad status");
endmodule

// ===== bench/chained_hash_table_with_tombstones_core_tb.sv =====
// testbench for chained_hash_table_with_tombstones_core: streams insert, remove and lookup
// requests with bursty input and a stalling receiver, checks every result against a local table model
// depends on chht_pkg and the core rtl
`timescale 1ns / 1ps
module chained_hash_table_with_tombstones_core_tb;

  localparam int NB = 64;
  localparam int NP = 1024;
  localparam logic [1:0] FUNC_LOOKUP = 2'd2;
  localparam logic [1:0] FUNC_SPARE  = 2'd3;

  // outcome of one operation on the table
  typedef struct packed {
    logic [2:0] status;
    logic       present;
  } outcome_t;

  // table model plus the queue of outcomes still to arrive
  class table_scoreboard;
    logic [10:0] heads[NB];
    logic [63:0] keys[NP];
    logic        active[NP];
    logic [10:0] links[NP];
    int          pool_used;
    outcome_t    pending[$];
    int          errors;

    function new();
      foreach (heads[i]) heads[i] = '0;
      pool_used = 0;
      errors = 0;
    endfunction

    function int bucket_of(logic [63:0] key);
      int h;
      logic [7:0] c;
      h = 0;
      for (int b = 5; b <= 7; b++) begin
        c = key[8*(7-b) +: 8];
        if (c == 0) break;
        h = (h * 31 + c) % NB;
      end
      return h;
    endfunction

    // walk the chain, apply the operation, queue its outcome
    function void note_request(logic [1:0] fn, logic [63:0] key);
      int bkt, steps, tomb, tail, hit, n;
      logic [10:0] lnk;
      bit has_tomb, has_tail, found;
      outcome_t o;
      bkt = bucket_of(key);
      lnk = heads[bkt];
      has_tomb = 0; has_tail = 0; found = 0;
      tomb = 0; tail = 0; hit = 0; steps = 0;
      while (lnk[10] && steps < NP) begin
        if (keys[lnk[9:0]] == key) begin
          found = 1;
          hit = lnk[9:0];
          break;
        end
        if (!active[lnk[9:0]] && !has_tomb) begin
          has_tomb = 1;
          tomb = lnk[9:0];
        end
        has_tail = 1;
        tail = lnk[9:0];
        lnk = links[lnk[9:0]];
        steps++;
      end
      if (fn == chht_pkg::FUNC_INSERT) begin
        if (found) begin
          o.status = active[hit] ? chht_pkg::ST_PRESENT : chht_pkg::ST_REACTIVATED;
          active[hit] = 1;
          o.present = 1;
        end else if (has_tomb) begin
          // tombstone reused in place, its link kept
          keys[tomb] = key;
          active[tomb] = 1;
          o = '{chht_pkg::ST_INSERTED, 1'b1};
        end else if (pool_used < NP) begin
          n = pool_used;
          keys[n] = key;
          active[n] = 1;
          links[n] = '0;
          if (has_tail) links[tail] = {1'b1, 10'(n)};
          else heads[bkt] = {1'b1, 10'(n)};
          pool_used++;
          o = '{chht_pkg::ST_INSERTED, 1'b1};
        end else begin
          o = '{chht_pkg::ST_FULL, 1'b0};
        end
      end else if (fn == chht_pkg::FUNC_REMOVE) begin
        if (found && active[hit]) begin
          active[hit] = 0;
          o.status = chht_pkg::ST_REMOVED;
        end else begin
          o.status = chht_pkg::ST_NOT_FOUND;
        end
        o.present = 0;
      end else begin
        // lookup, and the spare code acting as one
        if (found && active[hit]) o = '{chht_pkg::ST_FOUND, 1'b1};
        else o = '{chht_pkg::ST_NOT_FOUND, 1'b0};
      end
      pending.push_back(o);
    endfunction

    function void check_result(logic [7:0] data);
      outcome_t want;
      if (pending.size() == 0) begin
        $error("unexpected result tdata=%h", data);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (data[2:0] != want.status) begin
        $error("status: expected %0d actual %0d", want.status, data[2:0]);
        errors++;
      end
      if (data[3] != want.present) begin
        $error("present: expected %0d actual %0d", want.present, data[3]);
        errors++;
      end
      if (data[7:4] != 0) begin
        $error("zero fill: expected 0 actual %h", data[7:4]);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;   // func[1:0], key[65:2], zero fill
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // status[2:0], present[3], zero fill

  table_scoreboard sb;
  logic [63:0] key_pool[$];  // keys already used, for hits and re-inserts
  bit          stim_done;

  chained_hash_table_with_tombstones_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // hard limit well above the slowest correct run
  initial begin
    #20000000;
    $display("Regression FAIL");
    $finish;
  end

  // send one request and hold it until the handshake
  task automatic send_request(logic [1:0] fn, logic [63:0] key);
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, key, fn};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(fn, key);
    key_pool.push_back(key);
  endtask

  task automatic idle_input(int n);
    in_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // random key: half of the time a reused one, bucket bytes often holding zeros
  function automatic logic [63:0] pick_key();
    logic [63:0] k;
    int r;
    r = $urandom_range(0, 9);
    if (r < 5 && key_pool.size() > 0)
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
    k = {$urandom(), $urandom()};
    if (r == 5) k[23:0] = {8'h41 + 8'($urandom_range(0, 3)), 16'h0};
    if (r == 6) k[15:0] = {8'($urandom_range(0, 255)), 8'h00};
    if (r == 7) k[23:0] = 24'($urandom_range(0, 63));
    return k;
  endfunction

  // receiver stalls in its own pattern, with quiet stretches
  initial begin
    int phase;
    out_tready <= 1'b0;
    phase = 0;
    forever begin
      @(posedge clk);
      phase++;
      if ((phase / 500) % 3 == 2) out_tready <= 1'b1;
      else out_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  // check results accepted at each edge
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  initial begin
    int burst, guard;
    logic [1:0] fn;
    sb = new();
    stim_done = 0;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: key extremes, every operation, spare code, tombstone paths
    send_request(FUNC_LOOKUP, 64'h0);
    send_request(chht_pkg::FUNC_INSERT, 64'h0);
    send_request(chht_pkg::FUNC_INSERT, 64'h0);
    send_request(chht_pkg::FUNC_INSERT, '1);
    send_request(FUNC_SPARE, '1);
    send_request(chht_pkg::FUNC_REMOVE, '1);
    send_request(chht_pkg::FUNC_REMOVE, '1);
    send_request(FUNC_LOOKUP, '1);
    send_request(chht_pkg::FUNC_INSERT, '1);
    send_request(chht_pkg::FUNC_INSERT, 64'h4142434445000000);
    send_request(chht_pkg::FUNC_INSERT, 64'h4142434445410000);
    send_request(chht_pkg::FUNC_REMOVE, 64'h4142434445000000);
    send_request(chht_pkg::FUNC_INSERT, 64'h5A5A5A5A5A000000);
    send_request(FUNC_LOOKUP, 64'h5A5A5A5A5A000000);
    send_request(FUNC_LOOKUP, 64'h4142434445000000);
    send_request(chht_pkg::FUNC_REMOVE, 64'h7777777777777777);
    idle_input(3);

    // random: bursts of mixed requests before the pool is filled
    for (int i = 0; i < 120; i += burst) begin
      burst = $urandom_range(1, 20);
      for (int j = 0; j < burst; j++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: fn = chht_pkg::FUNC_INSERT;
          5, 6:          fn = chht_pkg::FUNC_REMOVE;
          7, 8:          fn = FUNC_LOOKUP;
          default:       fn = FUNC_SPARE;
        endcase
        send_request(fn, pick_key());
      end
      if ($urandom_range(0, 3) != 0) idle_input($urandom_range(1, 12));
    end
    // fill the pool to reach the full case, then probe it
    while (sb.pool_used < NP)
      send_request(chht_pkg::FUNC_INSERT, {$urandom(), $urandom()});
    for (int j = 0; j < 10; j++)
      send_request(chht_pkg::FUNC_INSERT, {$urandom(), $urandom()});
    for (int j = 0; j < 10; j++) send_request(FUNC_LOOKUP, pick_key());
    in_tvalid <= 1'b0;

    guard = 0;
    while (sb.pending.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
